/* sv/srbs_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and functions of the settings record bank selector
// no dependencies; the srbs modules refer to this package by scoped names

package srbs_pkg;

  // sizing
  localparam int PROGRAM_SLOTS = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // record format
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] COMMIT_WORD = 32'h544D_4F43;
  // magic bytes in byte order: 'E' 'S' 'T' 'C', byte 0 in the low lane
  localparam logic [31:0] MAGIC_WORD  = 32'h4354_5345;
  localparam logic [7:0]  FMT_VERSION = 8'd1;
  localparam logic [7:0]  REC_BYTES   = 8'd32;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam logic [7:0]  PCT_MAX     = 8'd100;
  localparam logic [4:0]  LAST_POS    = 5'd31;

  // record kinds
  localparam logic [2:0] KIND_ERASED    = 3'd0;
  localparam logic [2:0] KIND_VALID     = 3'd1;
  localparam logic [2:0] KIND_OWNED_BAD = 3'd2;
  localparam logic [2:0] KIND_FOREIGN   = 3'd3;
  localparam logic [2:0] KIND_READ_ERR  = 3'd4;

  // active bank codes
  localparam logic [1:0] ACT_BANK0    = 2'd0;
  localparam logic [1:0] ACT_BANK1    = 2'd1;
  localparam logic [1:0] ACT_NONE     = 2'd2;
  localparam logic [1:0] ACT_READ_ERR = 2'd3;

  // register indexes
  localparam logic [1:0] REG_LANG_A  = 2'd0;
  localparam logic [1:0] REG_LANG_B  = 2'd1;
  localparam logic [1:0] REG_LANG_C  = 2'd2;
  localparam logic [1:0] REG_NO_SLOT = 2'd3;

  typedef struct packed {
    logic [7:0] lang_a;
    logic [7:0] lang_b;
    logic [7:0] lang_c;
    logic [7:0] no_slot;
  } cfg_t;

  // one classified record, settings packed slot:lang:volume:backlight
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [31:0] set;
    logic        bank;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic fin_valid;
    logic record_open;
  } front_stat_t;

  // one byte of reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // value is one of 0, 10, ... 100
  function automatic logic is_tens(input logic [7:0] v);
    logic r;
    r = 1'b0;
    for (int k = 0; k <= 10; k++) begin
      if (v == 8'(k * 10)) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] default_settings(input cfg_t cfg);
    return {cfg.no_slot, cfg.lang_b, 8'd0, 8'd0};
  endfunction

  function automatic logic settings_ok(input logic [31:0] s, input cfg_t cfg);
    logic [7:0] bl;
    logic [7:0] vol;
    logic [7:0] lang;
    logic [7:0] slot;
    logic       ok;
    bl   = s[7:0];
    vol  = s[15:8];
    lang = s[23:16];
    slot = s[31:24];
    ok   = (bl != 8'd0) && (bl <= PCT_MAX) && is_tens(bl);
    ok   = ok && (vol <= PCT_MAX) && is_tens(vol);
    ok   = ok && ((lang == cfg.lang_a) || (lang == cfg.lang_b) || (lang == cfg.lang_c));
    ok   = ok && (({1'b0, slot} < 9'(PROGRAM_SLOTS)) || (slot == cfg.no_slot));
    return ok;
  endfunction

  // wrap-around sequence compare
  function automatic logic seq_is_newer(input logic [31:0] left, input logic [31:0] right);
    logic [31:0] d;
    d = left - right;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

/* sv/srbs_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for record bytes and selection results
// no dependencies

interface srbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       bank_select;
  logic       sector_erased;
  logic       read_failed;

  modport source(output valid, output data_byte, output bank_select,
                 output sector_erased, output read_failed, input ready);
  modport sink(input valid, input data_byte, input bank_select,
               input sector_erased, input read_failed, output ready);
endinterface

interface srbs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [31:0] sequence_number;
  logic [7:0]  backlight_level;
  logic [7:0]  volume_level;
  logic [7:0]  language_byte;
  logic [7:0]  recent_slot;
  logic [1:0]  active_bank;
  logic        selection_ready;

  modport source(output valid, output record_kind, output sequence_number,
                 output backlight_level, output volume_level, output language_byte,
                 output recent_slot, output active_bank, output selection_ready,
                 input ready);
  modport sink(input valid, input record_kind, input sequence_number,
               input backlight_level, input volume_level, input language_byte,
               input recent_slot, input active_bank, input selection_ready,
               output ready);
endinterface

/* sv/srbs_front.sv */
`timescale 1ns / 1ps
// front end: takes record bytes, runs the crc and latches header fields,
// then classifies each finished record; depends on srbs_pkg and srbs_if

module srbs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  srbs_pkg::cfg_t           cfg,
  srbs_in_if.sink                  in_ch,
  input  logic                     q_full,
  output srbs_pkg::push_t          push,
  output srbs_pkg::front_stat_t    stat
);

  // per-record scan state
  logic [4:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        allff_r, allff_nxt;
  logic        magic_r, magic_nxt;
  logic        marker_r, marker_nxt;
  logic [31:0] set_r, set_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] scrc_r, scrc_nxt;

  // finished-record stage
  logic        fin_valid_r, fin_valid_nxt;
  logic        fin_fail_r;
  logic        fin_bank_r;
  logic        fin_allff_r;
  logic        fin_erased_r;
  logic        fin_magic_r;
  logic        fin_marker_r;
  logic [31:0] fin_crc_r;
  logic [31:0] fin_scrc_r;
  logic [31:0] fin_set_r;
  logic [31:0] fin_seq_r;

  logic        accept;
  logic        last;
  logic        finish;
  logic [7:0]  b;
  logic [1:0]  lane;
  logic [1:0]  set_lane;
  logic [31:0] crc_upd;
  logic        upd_allff, upd_magic, upd_marker;
  logic [31:0] upd_set, upd_seq, upd_scrc;

  assign in_ch.ready = !(fin_valid_r && q_full);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign lane        = pos_r[1:0];
  assign set_lane    = pos_r[1:0] + 2'd2;
  assign last        = (pos_r == srbs_pkg::LAST_POS);
  assign finish      = accept && (in_ch.read_failed || last);

  // fold the current byte into the scan state
  always_comb begin
    upd_allff  = allff_r && (b == srbs_pkg::ERASED_BYTE);
    upd_magic  = magic_r;
    upd_marker = marker_r;
    upd_set    = set_r;
    upd_seq    = seq_r;
    upd_scrc   = scrc_r;
    priority if (pos_r < 5'd4) begin
      if (b != srbs_pkg::MAGIC_WORD[{lane, 3'b000} +: 8]) upd_magic = 1'b0;
    end else if (pos_r == 5'd4) begin
      if (b != srbs_pkg::FMT_VERSION) upd_marker = 1'b0;
    end else if (pos_r == 5'd5) begin
      if (b != srbs_pkg::REC_BYTES) upd_marker = 1'b0;
    end else if (pos_r <= 5'd9) begin
      upd_set[{set_lane, 3'b000} +: 8] = set_r[{set_lane, 3'b000} +: 8] | b;
    end else if (pos_r <= 5'd11) begin
      upd_set = set_r;
    end else if (pos_r <= 5'd15) begin
      upd_seq[{lane, 3'b000} +: 8] = seq_r[{lane, 3'b000} +: 8] | b;
    end else if (pos_r <= 5'd19) begin
      upd_scrc[{lane, 3'b000} +: 8] = scrc_r[{lane, 3'b000} +: 8] | b;
    end else if (pos_r <= 5'd23) begin
      if (b != srbs_pkg::COMMIT_WORD[{lane, 3'b000} +: 8]) upd_marker = 1'b0;
    end else begin
      upd_set = set_r;
    end
    // crc covers bytes 0-15 and 24-31
    crc_upd = (pos_r[4:3] == 2'b10) ? crc_r : srbs_pkg::crc_byte(crc_r, b);
  end

  // scan state next values
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    allff_nxt  = allff_r;
    magic_nxt  = magic_r;
    marker_nxt = marker_r;
    set_nxt    = set_r;
    seq_nxt    = seq_r;
    scrc_nxt   = scrc_r;
    if (finish) begin
      pos_nxt    = 5'd0;
      crc_nxt    = srbs_pkg::CRC_INIT;
      allff_nxt  = 1'b1;
      magic_nxt  = 1'b1;
      marker_nxt = 1'b1;
      set_nxt    = 32'd0;
      seq_nxt    = 32'd0;
      scrc_nxt   = 32'd0;
    end else if (accept) begin
      pos_nxt    = pos_r + 5'd1;
      crc_nxt    = crc_upd;
      allff_nxt  = upd_allff;
      magic_nxt  = upd_magic;
      marker_nxt = upd_marker;
      set_nxt    = upd_set;
      seq_nxt    = upd_seq;
      scrc_nxt   = upd_scrc;
    end
  end

  // finished stage holds until the queue takes it
  always_comb begin
    fin_valid_nxt = fin_valid_r;
    if (finish) begin
      fin_valid_nxt = 1'b1;
    end else if (push.valid) begin
      fin_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 5'd0;
      crc_r       <= srbs_pkg::CRC_INIT;
      allff_r     <= 1'b1;
      magic_r     <= 1'b1;
      marker_r    <= 1'b1;
      set_r       <= 32'd0;
      seq_r       <= 32'd0;
      scrc_r      <= 32'd0;
      fin_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      allff_r     <= allff_nxt;
      magic_r     <= magic_nxt;
      marker_r    <= marker_nxt;
      set_r       <= set_nxt;
      seq_r       <= seq_nxt;
      scrc_r      <= scrc_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  // finished record payload
  always_ff @(posedge clk) begin
    if (finish) begin
      fin_fail_r   <= in_ch.read_failed;
      fin_bank_r   <= in_ch.bank_select;
      fin_erased_r <= in_ch.sector_erased;
      fin_allff_r  <= upd_allff;
      fin_magic_r  <= upd_magic;
      fin_marker_r <= upd_marker;
      fin_crc_r    <= ~crc_upd;
      fin_scrc_r   <= upd_scrc;
      fin_set_r    <= upd_set;
      fin_seq_r    <= upd_seq;
    end
  end

  // classify the finished record
  always_comb begin
    push.valid    = fin_valid_r && !q_full;
    push.rec.bank = fin_bank_r;
    push.rec.seq  = 32'd0;
    push.rec.set  = srbs_pkg::default_settings(cfg);
    priority if (fin_fail_r) begin
      push.rec.kind = srbs_pkg::KIND_READ_ERR;
    end else if (fin_allff_r) begin
      push.rec.kind = fin_erased_r ? srbs_pkg::KIND_ERASED : srbs_pkg::KIND_FOREIGN;
    end else if (!fin_magic_r) begin
      push.rec.kind = srbs_pkg::KIND_FOREIGN;
    end else if (!fin_marker_r || (fin_scrc_r != fin_crc_r)) begin
      push.rec.kind = srbs_pkg::KIND_OWNED_BAD;
    end else begin
      push.rec.set = fin_set_r;
      if ((fin_seq_r != 32'd0) && srbs_pkg::settings_ok(fin_set_r, cfg)) begin
        push.rec.kind = srbs_pkg::KIND_VALID;
        push.rec.seq  = fin_seq_r;
      end else begin
        push.rec.kind = srbs_pkg::KIND_OWNED_BAD;
      end
    end
  end

  assign stat.fin_valid   = fin_valid_r;
  assign stat.record_open = (pos_r != 5'd0);

endmodule

/* sv/srbs_queue.sv */
`timescale 1ns / 1ps
// short queue of classified records between front and back end
// depends on srbs_pkg

module srbs_queue #(
  parameter int DEPTH = srbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srbs_pkg::push_t  push,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output srbs_pkg::rec_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srbs_pkg::rec_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots_r[wr_ptr_r] <= push.rec;
    end
  end

endmodule

/* sv/srbs_back.sv */
`timescale 1ns / 1ps
// back end: remembers the bank 0 result and picks the active bank on bank 1,
// holding each result in the output register; depends on srbs_pkg and srbs_if

module srbs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  srbs_pkg::rec_t  head,
  output logic            pop,
  srbs_out_if.source      out_ch
);

  // remembered bank 0 result
  logic [2:0]  b0_kind_r, b0_kind_nxt;
  logic [31:0] b0_seq_r, b0_seq_nxt;
  logic [31:0] b0_set_r, b0_set_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r;
  logic [31:0] seq_r;
  logic [31:0] set_r;
  logic [1:0]  active_r;
  logic        sel_ready_r;

  logic [1:0]  active;
  logic [31:0] rep_set;

  assign pop = !empty && (!out_valid_r || out_ch.ready);

  // active bank selection
  always_comb begin
    active = srbs_pkg::ACT_BANK0;
    if (head.bank) begin
      priority if ((b0_kind_r == srbs_pkg::KIND_READ_ERR) ||
                   (head.kind == srbs_pkg::KIND_READ_ERR)) begin
        active = srbs_pkg::ACT_READ_ERR;
      end else if (b0_kind_r != srbs_pkg::KIND_VALID) begin
        active = (head.kind == srbs_pkg::KIND_VALID) ? srbs_pkg::ACT_BANK1
                                                      : srbs_pkg::ACT_NONE;
      end else if (head.kind != srbs_pkg::KIND_VALID) begin
        active = srbs_pkg::ACT_BANK0;
      end else begin
        active = srbs_pkg::seq_is_newer(head.seq, b0_seq_r) ? srbs_pkg::ACT_BANK1
                                                             : srbs_pkg::ACT_BANK0;
      end
    end
    rep_set = (head.bank && (active == srbs_pkg::ACT_BANK0)) ? b0_set_r : head.set;
  end

  // bank 0 memory and output valid
  always_comb begin
    b0_kind_nxt   = b0_kind_r;
    b0_seq_nxt    = b0_seq_r;
    b0_set_nxt    = b0_set_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (!head.bank) begin
        b0_kind_nxt = head.kind;
        b0_seq_nxt  = head.seq;
        b0_set_nxt  = head.set;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_kind_r   <= srbs_pkg::KIND_READ_ERR;
      b0_seq_r    <= 32'd0;
      b0_set_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      b0_kind_r   <= b0_kind_nxt;
      b0_seq_r    <= b0_seq_nxt;
      b0_set_r    <= b0_set_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= head.kind;
      seq_r       <= head.seq;
      set_r       <= rep_set;
      active_r    <= active;
      sel_ready_r <= head.bank;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.record_kind     = kind_r;
  assign out_ch.sequence_number = seq_r;
  assign out_ch.backlight_level = set_r[7:0];
  assign out_ch.volume_level    = set_r[15:8];
  assign out_ch.language_byte   = set_r[23:16];
  assign out_ch.recent_slot     = set_r[31:24];
  assign out_ch.active_bank     = active_r;
  assign out_ch.selection_ready = sel_ready_r;

endmodule

/* sv/settings_record_bank_select_top.sv */
`timescale 1ns / 1ps
// top level of the settings record bank selector: register block, front end,
// record queue and back end; depends on srbs_pkg, srbs_if and the srbs modules

// Takes one byte of a 32-byte flash settings record per cycle on in_ch while
// in_ch ready is high, with no gaps needed between records or banks. Each
// record gives one result on out_ch when its byte 31 or a read failure is
// accepted; the result passes the crc/classify stage, then the queue and the
// selection output register. A stalled out_ch first fills the output register,
// then the QUEUE_DEPTH-entry record queue, and only then holds in_ch ready low,
// and then only for as long as the classify stage stays blocked. Bank 1 results
// carry the active-bank decision against the last bank 0 record since reset.
// The four 8-bit language and no-slot registers sit at byte addresses 0, 4, 8
// and 12 and are to be written only while no record is in flight.

module settings_record_bank_select_top #(
  parameter int QUEUE_DEPTH = srbs_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  srbs_in_if.sink                     in_ch,
  srbs_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srbs_pkg::ADDR_W-1:0] paddr,
  input  logic [srbs_pkg::DATA_W-1:0] pwdata,
  output logic [srbs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  srbs_pkg::cfg_t        cfg_r, cfg_nxt;
  srbs_pkg::push_t       push;
  srbs_pkg::front_stat_t front_stat;
  srbs_pkg::rec_t        head;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // configuration register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        srbs_pkg::REG_LANG_A:  cfg_nxt.lang_a  = pwdata[7:0];
        srbs_pkg::REG_LANG_B:  cfg_nxt.lang_b  = pwdata[7:0];
        srbs_pkg::REG_LANG_C:  cfg_nxt.lang_c  = pwdata[7:0];
        srbs_pkg::REG_NO_SLOT: cfg_nxt.no_slot = pwdata[7:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lang_a  <= 8'd0;
      cfg_r.lang_b  <= 8'd1;
      cfg_r.lang_c  <= 8'd2;
      cfg_r.no_slot <= 8'hFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // configuration register read
  always_comb begin
    unique case (reg_idx)
      srbs_pkg::REG_LANG_A:  prdata = {24'd0, cfg_r.lang_a};
      srbs_pkg::REG_LANG_B:  prdata = {24'd0, cfg_r.lang_b};
      srbs_pkg::REG_LANG_C:  prdata = {24'd0, cfg_r.lang_c};
      srbs_pkg::REG_NO_SLOT: prdata = {24'd0, cfg_r.no_slot};
      default:               prdata = '0;
    endcase
  end

  srbs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .stat   (front_stat)
  );

  srbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  srbs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // a read failure ends the record and leaves a finished record behind
  a_fail_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.read_failed)
      |=> (front_stat.fin_valid && !front_stat.record_open))
    else $error("read failure did not restart the record");

  // only a valid record reports a sequence number
  a_seq_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.record_kind != srbs_pkg::KIND_VALID))
      |-> (out_ch.sequence_number == 32'd0))
    else $error("sequence number on a record that is not valid");

  // a bank 0 result never carries a selection
  a_bank0_no_select: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.selection_ready)
      |-> (out_ch.active_bank == srbs_pkg::ACT_BANK0))
    else $error("bank 0 result with an active bank other than bank 0");

  // the classify stage is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (front_stat.fin_valid && q_full) |=> front_stat.fin_valid)
    else $error("finished record dropped while the queue was full");

endmodule
